@@ design/vigenere_stream_cipher_unit_assert.svh @@
// Assertion helpers for the cipher unit.
`ifndef VIGENERE_STREAM_CIPHER_UNIT_ASSERT_SVH
`define VIGENERE_STREAM_CIPHER_UNIT_ASSERT_SVH

// Same-cycle implication, held off while reset is high.
`define VSC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off while reset is high.
`define VSC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/vsc_pkg.sv @@
`default_nettype none

package vsc_pkg;

   localparam int unsigned KEY_ENTRIES = 8;
   localparam int unsigned SHIFT_W     = 5;
   localparam int unsigned KEY_W       = KEY_ENTRIES * SHIFT_W;
   localparam int unsigned LEN_W       = 4;
   localparam int unsigned ENTRY_IDX_W = $clog2(KEY_ENTRIES);

   typedef logic [KEY_ENTRIES-1:0][SHIFT_W-1:0] key_shifts_type;
   typedef logic [7:0]                          byte_type;

   // register indexes on the csr port
   localparam logic CSR_KEY_SHIFTS = 1'b0;
   localparam logic CSR_KEY_LENGTH = 1'b1;

   localparam key_shifts_type KEY_SHIFTS_RESET = KEY_W'(342578);
   localparam logic [LEN_W-1:0] KEY_LENGTH_RESET = LEN_W'(5);

   localparam byte_type LOWER_FIRST = 8'd97;
   localparam byte_type LOWER_LAST  = 8'd122;
   localparam byte_type UPPER_FIRST = 8'd65;
   localparam byte_type UPPER_LAST  = 8'd90;
   localparam byte_type DIGIT_FIRST = 8'd48;
   localparam byte_type DIGIT_LAST  = 8'd57;

   localparam logic [5:0] LETTER_MOD = 6'd26;
   localparam logic [5:0] DIGIT_MOD  = 6'd10;

   typedef struct packed {
      logic     coded;
      logic     digit;
      byte_type base;
   } char_class_type;

   function automatic char_class_type classify(input byte_type b);
      char_class_type c;
      c.coded = 1'b1;
      c.digit = 1'b0;
      c.base  = '0;
      if (b >= LOWER_FIRST && b <= LOWER_LAST) begin
         c.base = LOWER_FIRST;
      end else if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
         c.base = UPPER_FIRST;
      end else if (b >= DIGIT_FIRST && b <= DIGIT_LAST) begin
         c.base  = DIGIT_FIRST;
         c.digit = 1'b1;
      end else begin
         c.coded = 1'b0;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ design/vigenere_stream_cipher_unit.sv @@
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall req_in_byte[7:0]
// rsp       out        rsp_valid/rsp_stall rsp_out_byte[7:0]
// csr       in         csr_we (no wait)    csr_index, csr_wdata[39:0]
//
// One byte per cycle while rsp_stall is low; rsp_valid rises once the byte has passed
// the input register (holding byte and key shift) and reached the result register.
// Key position advances at accept of a letter or digit, so back-to-back coded bytes see consecutive shifts.
// Synchronous active-high reset empties both stages, zeroes the key position
// and loads the default key. Each stage holds its beat while downstream stalls;
// req_stall rises only when both stages are full and rsp_stall is high.
`default_nettype none

module vigenere_stream_cipher_unit
   import vsc_pkg::*;
#(
   parameter int unsigned MAX_KEY_LENGTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire byte_type         req_in_byte,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output byte_type              rsp_out_byte,
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [KEY_W-1:0] csr_wdata
);

   localparam int unsigned POS_W = (MAX_KEY_LENGTH > 1) ? $clog2(MAX_KEY_LENGTH) : 1;
   localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_KEY_LENGTH);

   key_shifts_type     key_shifts_ff, key_shifts_in;
   logic [LEN_W-1:0]   key_length_ff, key_length_in;
   logic [POS_W-1:0]   key_pos_ff, key_pos_in;

   logic               s1_valid_ff, s1_valid_in;
   byte_type           s1_byte_ff, s1_byte_in;
   logic [SHIFT_W-1:0] s1_shift_ff, s1_shift_in;
   logic               s2_valid_ff, s2_valid_in;
   byte_type           s2_byte_ff, s2_byte_in;

   logic               req_take, s1_move, s2_ready;
   char_class_type     req_class;
   logic [LEN_W-1:0]   used_len, pos_plus;
   logic [ENTRY_IDX_W-1:0] entry_idx;
   byte_type           cipher_byte;

   vsc_cipher u_cipher (
      .plain_byte  (s1_byte_ff),
      .shift       (s1_shift_ff),
      .cipher_byte (cipher_byte)
   );

   always_comb begin
      s2_ready  = !s2_valid_ff || !rsp_stall;
      s1_move   = s1_valid_ff && s2_ready;
      req_stall = s1_valid_ff && !s2_ready;
      req_take  = req_valid && !req_stall;
      req_class = classify(req_in_byte);
      entry_idx = ENTRY_IDX_W'(key_pos_ff);

      used_len = key_length_ff;
      if (used_len == '0) begin
         used_len = LEN_W'(1);
      end else if (used_len > MaxLen) begin
         used_len = MaxLen;
      end
      pos_plus = LEN_W'(key_pos_ff) + LEN_W'(1);

      key_shifts_in = key_shifts_ff;
      key_length_in = key_length_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_KEY_SHIFTS: key_shifts_in = csr_wdata;
            CSR_KEY_LENGTH: key_length_in = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end

      key_pos_in = key_pos_ff;
      if (req_take && req_class.coded) begin
         if (pos_plus >= used_len) begin
            key_pos_in = '0;
         end else begin
            key_pos_in = POS_W'(pos_plus);
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_shift_in = s1_shift_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_in_byte;
         s1_shift_in = key_shifts_ff[entry_idx];
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      s2_byte_in  = s2_byte_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
         s2_byte_in  = cipher_byte;
      end else if (s2_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_shifts_ff <= KEY_SHIFTS_RESET;
         key_length_ff <= KEY_LENGTH_RESET;
         key_pos_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
      end else begin
         key_shifts_ff <= key_shifts_in;
         key_length_ff <= key_length_in;
         key_pos_ff    <= key_pos_in;
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff  <= s1_byte_in;
      s1_shift_ff <= s1_shift_in;
      s2_byte_ff  <= s2_byte_in;
   end

   assign rsp_valid    = s2_valid_ff;
   assign rsp_out_byte = s2_byte_ff;

`include "vigenere_stream_cipher_unit_assert.svh"

   `VSC_ASSERT_NOW(a_pos_in_range, clock, reset, 1'b1, LEN_W'(key_pos_ff) < MaxLen, "key position out of range")
   `VSC_ASSERT_NEXT(a_pos_hold_plain, clock, reset, req_take && !req_class.coded, $stable(key_pos_ff), "key advanced on pass-through beat")
   `VSC_ASSERT_NOW(a_full_stalls, clock, reset, s1_valid_ff && s2_valid_ff && rsp_stall, req_stall, "beat taken with both stages full")

endmodule

`default_nettype wire

@@ design/vsc_cipher.sv @@
`default_nettype none

module vsc_cipher
   import vsc_pkg::*;
(
   input  wire byte_type           plain_byte,
   input  wire logic [SHIFT_W-1:0] shift,
   output byte_type                cipher_byte
);

   localparam logic [5:0] DIGIT_MOD_X2  = 6'(2 * DIGIT_MOD);
   localparam logic [5:0] DIGIT_MOD_X3  = 6'(3 * DIGIT_MOD);
   localparam logic [5:0] DIGIT_MOD_X4  = 6'(4 * DIGIT_MOD);
   localparam logic [5:0] LETTER_MOD_X2 = 6'(2 * LETTER_MOD);

   char_class_type cls;
   byte_type       offset;
   logic [5:0]     sum;      // offset (<26) plus shift (<32): at most 56
   logic [5:0]     rem;

   always_comb begin
      cls    = classify(plain_byte);
      offset = plain_byte - cls.base;
      sum    = 6'(offset[4:0]) + 6'(shift);
      rem    = sum;
      if (cls.digit) begin
         // at most 40, so four steps of ten cover it
         if (sum >= DIGIT_MOD_X4) begin
            rem = sum - DIGIT_MOD_X4;
         end else if (sum >= DIGIT_MOD_X3) begin
            rem = sum - DIGIT_MOD_X3;
         end else if (sum >= DIGIT_MOD_X2) begin
            rem = sum - DIGIT_MOD_X2;
         end else if (sum >= DIGIT_MOD) begin
            rem = sum - DIGIT_MOD;
         end
      end else begin
         if (sum >= LETTER_MOD_X2) begin
            rem = sum - LETTER_MOD_X2;
         end else if (sum >= LETTER_MOD) begin
            rem = sum - LETTER_MOD;
         end
      end
      if (cls.coded) begin
         cipher_byte = cls.base + 8'(rem);
      end else begin
         cipher_byte = plain_byte;
      end
   end

endmodule

`default_nettype wire

@@ tb/cipher_stream_checker.sv @@
`timescale 1ns / 100ps

module cipher_stream_checker
   import vsc_pkg::*;
#(
   parameter int unsigned MAX_KEY_LENGTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  byte_type         req_in_byte,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  byte_type         rsp_out_byte,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [KEY_W-1:0] csr_wdata,
   output int               mismatch_count,
   output int               open_count,
   output int               checked_count,
   output int               shifted_count
);

   typedef struct {
      byte_type plain;
      byte_type cipher;
   } cipher_beat_type;

   cipher_beat_type        expected_cipher_q[$];
   key_shifts_type         key_copy;
   logic [LEN_W-1:0]       length_copy;
   logic [ENTRY_IDX_W-1:0] key_pos;

   function automatic int effective_length(input logic [LEN_W-1:0] len);
      if (len == 0) return 1;
      if (len > MAX_KEY_LENGTH) return MAX_KEY_LENGTH;
      return int'(len);
   endfunction

   // shifts letters and digits by the current key entry, advancing the position
   task automatic encipher_byte(input byte_type plain, output byte_type cipher,
                                output bit shifted);
      int base;
      int span;
      int shift;
      base    = 0;
      span    = 1;
      shifted = 1'b1;
      if (plain >= LOWER_FIRST && plain <= LOWER_LAST) begin
         base = LOWER_FIRST;
         span = LETTER_MOD;
      end else if (plain >= UPPER_FIRST && plain <= UPPER_LAST) begin
         base = UPPER_FIRST;
         span = LETTER_MOD;
      end else if (plain >= DIGIT_FIRST && plain <= DIGIT_LAST) begin
         base = DIGIT_FIRST;
         span = DIGIT_MOD;
      end else begin
         shifted = 1'b0;
      end
      cipher = plain;
      if (shifted) begin
         shift  = int'(key_copy[key_pos]);
         cipher = byte_type'(base + (int'(plain) - base + shift) % span);
         // a position left beyond a shortened key still wraps to zero here
         if (int'(key_pos) + 1 >= effective_length(length_copy)) begin
            key_pos = '0;
         end else begin
            key_pos = key_pos + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      cipher_beat_type beat;
      bit              coded;
      if (reset) begin
         key_copy       = KEY_SHIFTS_RESET;
         length_copy    = KEY_LENGTH_RESET;
         key_pos        = '0;
         mismatch_count = 0;
         checked_count  = 0;
         shifted_count  = 0;
         expected_cipher_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_cipher_q.size() == 0) begin
               $display("%0t: out_byte 0x%02h returned with no byte outstanding",
                        $time, rsp_out_byte);
               mismatch_count++;
            end else begin
               beat = expected_cipher_q.pop_front();
               checked_count++;
               if (rsp_out_byte !== beat.cipher) begin
                  $display("%0t: out_byte for 0x%02h: expected 0x%02h, actual 0x%02h",
                           $time, beat.plain, beat.cipher, rsp_out_byte);
                  mismatch_count++;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_KEY_SHIFTS) begin
               key_copy = csr_wdata;
            end else begin
               length_copy = csr_wdata[LEN_W-1:0];
            end
         end
         if (req_valid && !req_stall) begin
            beat.plain = req_in_byte;
            encipher_byte(req_in_byte, beat.cipher, coded);
            if (coded) shifted_count++;
            expected_cipher_q.push_back(beat);
         end
      end
      open_count = expected_cipher_q.size();
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import vsc_pkg::*;

   localparam int unsigned MAX_KEY_LENGTH = 8;
   localparam int IDLE_LIMIT  = 1000;
   localparam int PHASES      = 10;
   localparam int PHASE_BYTES = 84;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   byte_type         req_in_byte;
   logic             rsp_valid;
   logic             rsp_stall;
   byte_type         rsp_out_byte;
   logic             csr_we;
   logic             csr_index;
   logic [KEY_W-1:0] csr_wdata;

   int mismatch_count;
   int open_count;
   int checked_count;
   int shifted_count;
   int key_settings;
   int idle_cycles;
   bit sender_idles;
   bit sink_stalls;

   vigenere_stream_cipher_unit #(.MAX_KEY_LENGTH(MAX_KEY_LENGTH)) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   cipher_stream_checker #(.MAX_KEY_LENGTH(MAX_KEY_LENGTH)) cipher_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .open_count     (open_count),
      .checked_count  (checked_count),
      .shifted_count  (shifted_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // sink stalls in random bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_stalls && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // called and returns at a falling edge; valid stays high after the beat
   task automatic send_byte(input byte_type plain);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= plain;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (open_count != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [KEY_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      if (index == CSR_KEY_SHIFTS) key_settings++;
   endtask

   function automatic byte_type pick_byte();
      byte_type edges[10] = '{8'd47, 8'd58, 8'd64, 8'd91, 8'd96, 8'd123,
                              8'd0, 8'd255, 8'd127, 8'd128};
      case ($urandom_range(0, 9))
         0, 1, 2: return byte_type'($urandom_range(LOWER_FIRST, LOWER_LAST));
         3, 4:    return byte_type'($urandom_range(UPPER_FIRST, UPPER_LAST));
         5, 6:    return byte_type'($urandom_range(DIGIT_FIRST, DIGIT_LAST));
         7:       return edges[$urandom_range(0, 9)];
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin
      key_shifts_type   odd_key;
      byte_type         edge_bytes[16] = '{8'd0, 8'd255, "a", "z", "A", "Z", "0", "9",
                                           8'd96, 8'd123, 8'd64, 8'd91, 8'd47, 8'd58,
                                           8'd127, 8'd128};
      logic [KEY_W-1:0] shifts;
      logic [KEY_W-1:0] len_word;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_in_byte  = '0;
      csr_we       = 1'b0;
      csr_index    = CSR_KEY_SHIFTS;
      csr_wdata    = '0;
      sender_idles = 1'b0;
      sink_stalls  = 1'b0;
      key_settings = 1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default key: class boundaries and high bytes
      foreach (edge_bytes[i]) send_byte(edge_bytes[i]);

      // entries above 25 and a full-length key
      drain();
      odd_key = {5'd9, 5'd30, 5'd13, 5'd1, 5'd0, 5'd26, 5'd31, 5'd25};
      write_csr(CSR_KEY_SHIFTS, odd_key);
      write_csr(CSR_KEY_LENGTH, KEY_W'(8));
      send_byte("z");
      send_byte("Z");
      send_byte("9");

      // zero length acts as one; position 4 is beyond it and must wrap
      drain();
      write_csr(CSR_KEY_LENGTH, KEY_W'(0));
      send_byte("m");
      send_byte("5");

      // 15 clamps to the maximum length
      drain();
      write_csr(CSR_KEY_LENGTH, {{(KEY_W-LEN_W){1'b1}}, 4'hF});
      send_byte("b");
      send_byte("Q");

      for (int p = 0; p < PHASES; p++) begin
         drain();
         shifts   = KEY_W'({$urandom(), $urandom()});
         len_word = KEY_W'({$urandom(), $urandom()});
         case (p)
            0: begin
               shifts = '0;
               len_word[LEN_W-1:0] = 4'd1;
            end
            1: begin
               shifts = '1;
               len_word[LEN_W-1:0] = 4'd8;
            end
            2: len_word[LEN_W-1:0] = 4'd0;
            3: len_word[LEN_W-1:0] = 4'd15;
            4: begin
               for (int e = 0; e < KEY_ENTRIES; e++) shifts[e*SHIFT_W +: SHIFT_W] = 5'd25;
               len_word[LEN_W-1:0] = 4'($urandom_range(1, 8));
            end
            default: len_word[LEN_W-1:0] = 4'($urandom_range(0, 15));
         endcase
         if (p == 5) begin
            write_csr(CSR_KEY_LENGTH, len_word);
         end else begin
            write_csr(CSR_KEY_SHIFTS, shifts);
            write_csr(CSR_KEY_LENGTH, len_word);
         end
         sender_idles = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
         sink_stalls  = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
         for (int i = 0; i < PHASE_BYTES; i++) begin
            if (i == PHASE_BYTES / 2) begin
               if (p == 6 || $urandom_range(0, 2) == 0) drain();
               if (p < PHASES - 2) begin
                  sender_idles = $urandom_range(0, 1);
                  sink_stalls  = $urandom_range(0, 1);
               end
            end
            send_byte(pick_byte());
         end
      end

      drain();
      repeat (8) @(negedge clock);
      $display("Enciphered %0d bytes, %0d of them letters or digits, under %0d keys;",
               checked_count, shifted_count, key_settings);
      $display("lengths 0 to 15, shifts up to 31, with and without gaps and stalls.");
      if (mismatch_count == 0 && open_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
